// ----- src/krt_pkg.sv -----
// ============================================================================
// krt_pkg: shared types and constants for the keyed record table
// Field widths, action and status codes, controller states, channel payloads
// and the command/status bundles between controller and datapath.
// ============================================================================
package krt_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF         = 16;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int PAYLOAD_WIDTH_DEF = 64;

    // Channel field widths
    localparam int ACTION_W = 2;
    localparam int IDX_W    = 4;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 64;
    localparam int STATUS_W = 2;
    localparam int ROW_W    = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_GET    = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET_RD,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    typedef struct packed {
        action_t            action;
        logic [IDX_W-1:0]   row_index;
        logic [KEY_W-1:0]   search_key;
        logic [KEY_W-1:0]   record_key;
        logic [PAY_W-1:0]   record_payload;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ROW_W-1:0]   row_count;
        logic [KEY_W-1:0]   read_key;
        logic [PAY_W-1:0]   read_payload;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic    take;         // ready for a new item
        logic    get_rd;       // read the row named by the index
        logic    scan_rd;      // read the row at the scan pointer and advance
        logic    upd_wr;       // overwrite the row just compared
        logic    append;       // write the new record after the last row
        logic    shift_start;  // restart the pointer just past the hit row
        logic    shift_wr;     // move the row just read down by one
        logic    drop_row;     // decrement the row count
        logic    set_status;
        status_t status;
        logic    load;         // load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic    req_valid;
        logic    req_get;
        action_t act;
        logic    idx_ok;
        logic    full;
        logic    issue_left;
        logic    cmp_vld;
        logic    hit;
        logic    found;
        logic    out_free;
    } stat_t;

endpackage

// ----- src/krt_chan_if.sv -----
// ============================================================================
// krt_chan_if: valid/ready channel
// Carries one payload per transfer; a transfer happens when valid and ready
// are both high at a rising clock edge.
// ============================================================================
interface krt_chan_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/krt_ctrl.sv -----
// ============================================================================
// krt_ctrl: keyed record table controller
// Sequences get, scan, shift and result hand-off; drives the datapath with
// commands and reads back its status.
// ============================================================================
module krt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  krt_pkg::stat_t stat,
    output krt_pkg::cmd_t  cmd
);
    import krt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (stat.req_valid)
                begin
                    state_next = stat.req_get ? S_GET_RD : S_SCAN;
                end
            end
            S_GET_RD:
            begin
                cmd.get_rd     = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = stat.idx_ok ? ST_OK : ST_RANGE;
                state_next     = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.hit)
                begin
                    case (stat.act)
                        ACT_ADD:
                        begin
                            cmd.scan_rd    = 1'b0;
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_MISS;
                            state_next     = S_FINISH;
                        end
                        ACT_REMOVE:
                        begin
                            cmd.scan_rd     = 1'b0;
                            cmd.shift_start = 1'b1;
                            state_next      = S_SHIFT;
                        end
                        default:
                        begin
                            cmd.upd_wr = 1'b1;
                        end
                    endcase
                end
                else if (!stat.issue_left && !stat.cmp_vld)
                begin
                    // Scan drained with no terminating hit
                    cmd.set_status = 1'b1;
                    state_next     = S_FINISH;
                    case (stat.act)
                        ACT_ADD:
                        begin
                            if (stat.full)
                            begin
                                cmd.status = ST_FULL;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                                cmd.status = ST_OK;
                            end
                        end
                        ACT_UPDATE:
                        begin
                            cmd.status = stat.found ? ST_OK : ST_MISS;
                        end
                        default:
                        begin
                            cmd.status = ST_MISS;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                cmd.scan_rd  = 1'b1;
                cmd.shift_wr = stat.cmp_vld;
                if (!stat.issue_left && !stat.cmp_vld)
                begin
                    cmd.drop_row   = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OK;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Hold until the result register is free
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/krt_dpath.sv -----
// ============================================================================
// krt_dpath: keyed record table datapath
// Row memories with one write and one registered read port, item capture,
// row count, scan pointer, key compare and the result register.
// ============================================================================
module krt_dpath #(
    parameter int DEPTH         = krt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH     = krt_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = krt_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  krt_pkg::cmd_t  cmd,
    output krt_pkg::stat_t stat,
    input  logic           req_valid,
    input  krt_pkg::req_t  req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output krt_pkg::rsp_t  rsp_data
);
    import krt_pkg::*;

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IXW = (CW > IDX_W) ? CW : IDX_W;

    logic [KEY_WIDTH-1:0]     key_mem [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pay_mem [DEPTH];

    // Captured item
    action_t                  act_reg,  act_next;
    logic [IDX_W-1:0]         idx_reg,  idx_next;
    logic [KEY_WIDTH-1:0]     skey_reg, skey_next;
    logic [KEY_WIDTH-1:0]     rkey_reg, rkey_next;
    logic [PAYLOAD_WIDTH-1:0] rpay_reg, rpay_next;
    status_t                  stat_reg, stat_next;

    // Control state
    logic [CW-1:0]            count_reg,  count_next;
    logic [CW-1:0]            ptr_reg,    ptr_next;
    logic [AW-1:0]            rd_ptr_reg, rd_ptr_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic                     found_reg,  found_next;
    logic                     out_vld_reg, out_vld_next;
    rsp_t                     out_reg,    out_next;

    // Memory read data
    logic [KEY_WIDTH-1:0]     rd_key_reg;
    logic [PAYLOAD_WIDTH-1:0] rd_pay_reg;

    logic                     fire;
    logic                     idx_ok;
    logic                     issue_left;
    logic                     hit;
    logic [KEY_WIDTH-1:0]     cmp_key;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [KEY_WIDTH-1:0]     wr_key;
    logic [PAYLOAD_WIDTH-1:0] wr_pay;
    logic                     show_row;

    assign fire       = req_valid && cmd.take;
    assign idx_ok     = IXW'(idx_reg) < IXW'(count_reg);
    assign issue_left = ptr_reg < count_reg;
    assign cmp_key    = (act_reg == ACT_ADD) ? rkey_reg : skey_reg;
    assign hit        = rd_vld_reg && (rd_key_reg == cmp_key);

    assign rd_en   = (cmd.get_rd && idx_ok) || (cmd.scan_rd && issue_left);
    assign rd_addr = cmd.get_rd ? AW'(idx_reg) : ptr_reg[AW-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_ptr_reg;
        wr_key  = rkey_reg;
        wr_pay  = rpay_reg;
        if (cmd.upd_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.append)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[AW-1:0];
        end
        else if (cmd.shift_wr)
        begin
            // Row read last cycle drops into the slot below it
            wr_en   = 1'b1;
            wr_addr = rd_ptr_reg - AW'(1);
            wr_key  = rd_key_reg;
            wr_pay  = rd_pay_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_pay;
        end
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_pay_reg <= pay_mem[rd_addr];
        end
    end

    assign show_row = (act_reg == ACT_GET) && (stat_reg == ST_OK);

    always_comb
    begin
        act_next  = act_reg;
        idx_next  = idx_reg;
        skey_next = skey_reg;
        rkey_next = rkey_reg;
        rpay_next = rpay_reg;
        if (fire)
        begin
            act_next  = req_data.action;
            idx_next  = req_data.row_index;
            skey_next = KEY_WIDTH'(req_data.search_key);
            rkey_next = KEY_WIDTH'(req_data.record_key);
            rpay_next = PAYLOAD_WIDTH'(req_data.record_payload);
        end

        stat_next = cmd.set_status ? cmd.status : stat_reg;

        rd_vld_next = cmd.scan_rd && issue_left;
        rd_ptr_next = rd_vld_next ? ptr_reg[AW-1:0] : rd_ptr_reg;
        ptr_next    = ptr_reg;
        if (fire)
        begin
            ptr_next = '0;
        end
        else if (cmd.shift_start)
        begin
            ptr_next = CW'(rd_ptr_reg) + CW'(1);
        end
        else if (rd_vld_next)
        begin
            ptr_next = ptr_reg + CW'(1);
        end

        found_next = fire ? 1'b0 : (found_reg || cmd.upd_wr);

        count_next = count_reg;
        if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.drop_row)
        begin
            count_next = count_reg - CW'(1);
        end

        out_next     = out_reg;
        out_vld_next = out_vld_reg && !rsp_ready;
        if (cmd.load)
        begin
            out_vld_next          = 1'b1;
            out_next.status       = stat_reg;
            out_next.row_count    = ROW_W'(count_reg);
            out_next.read_key     = show_row ? KEY_W'(rd_key_reg) : '0;
            out_next.read_payload = show_row ? PAY_W'(rd_pay_reg) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        idx_reg  <= idx_next;
        skey_reg <= skey_next;
        rkey_reg <= rkey_next;
        rpay_reg <= rpay_next;
        stat_reg <= stat_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            rd_ptr_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            rd_vld_reg  <= rd_vld_next;
            found_reg   <= found_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign rsp_valid = out_vld_reg;
    assign rsp_data  = out_reg;

    always_comb
    begin
        stat.req_valid  = req_valid;
        stat.req_get    = (req_data.action == ACT_GET);
        stat.act        = act_reg;
        stat.idx_ok     = idx_ok;
        stat.full       = (count_reg == CW'(DEPTH));
        stat.issue_left = issue_left;
        stat.cmp_vld    = rd_vld_reg;
        stat.hit        = hit;
        stat.found      = found_reg;
        stat.out_free   = !out_vld_reg || rsp_ready;
    end

endmodule

// ----- src/keyed_record_table.sv -----
// ============================================================================
// keyed_record_table: packed table of keyed records
// Get by index, add, update by key and remove by key over a packed row table.
// ============================================================================
// Operation: a get reads the row named by the index; add, update and
//   remove scan the rows from the first, and a remove that hits then moves
//   each later row down by one.
// Throughput: one item at a time; the single memory read port scans one
//   row per cycle.
// Reset: row count cleared, result register empty; row memories not cleared.
module keyed_record_table #(
    parameter int DEPTH         = krt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH     = krt_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = krt_pkg::PAYLOAD_WIDTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    krt_chan_if.sink   req,
    krt_chan_if.source rsp
);
    import krt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign req.ready = cmd.take;

    krt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    krt_dpath #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_valid (req.valid),
        .req_data  (req.data),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp.data)
    );

endmodule

// ----- src/krt_checker.sv -----
// ============================================================================
// krt_checker: port-level checks for the keyed record table
// Watches the request and result channels and flags behavior that the
// block must never show.
// ============================================================================
module krt_checker #(
    parameter int DEPTH = krt_pkg::DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input krt_pkg::rsp_t rsp_data
);
    import krt_pkg::*;

    localparam logic [ROW_W-1:0] FULL_COUNT = ROW_W'(DEPTH);

    a_rsp_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("new item taken while one is in work");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_OK
            |-> rsp_data.read_key == '0 && rsp_data.read_payload == '0)
        else $error("failed action returned row data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.row_count == FULL_COUNT)
        else $error("full status with table not full");

endmodule

bind keyed_record_table krt_checker #(
    .DEPTH (DEPTH)
) u_krt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// ----- bench/tb_keyed_record_table.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_keyed_record_table: self-checking bench for the keyed record table
// A short table of directed actions covers empty and full tables, duplicate
// keys, missed searches, out-of-range reads and equal keys after an update.
// Random actions then drift the table between empty and full. Every result
// is compared field by field with a scoreboard fed by an in-bench table model
// or, for some directed rows, by fixed expected values.
module tb_keyed_record_table;
    import krt_pkg::*;

    localparam int ROWS         = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 600;
    localparam int QUIET_ITEMS  = 100;
    localparam int PHASE_LEN    = 40;
    localparam int LONG_HOLD    = 300;
    localparam int POOL_SIZE    = 24;
    localparam bit FIXED        = 1'b1;
    localparam bit PREDICT      = 1'b0;

    // One directed row; reps > 1 repeats it with key and payload stepped by one.
    typedef struct packed {
        action_t          act;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] skey;
        logic [KEY_W-1:0] rkey;
        logic [PAY_W-1:0] pay;
        logic [4:0]       reps;
        logic             fixed_result;
        status_t          want_status;
        logic [ROW_W-1:0] want_rows;
    } step_row_t;

    step_row_t directed_rows [19] = '{
        '{ACT_GET,    4'd0,  32'd0,        32'd0,        64'd0, 5'd1, FIXED,   ST_RANGE, 5'd0},
        '{ACT_REMOVE, 4'd0,  32'd5,        32'd0,        64'd0, 5'd1, FIXED,   ST_MISS,  5'd0},
        '{ACT_UPDATE, 4'd0,  32'd5,        32'd6,        64'd7, 5'd1, FIXED,   ST_MISS,  5'd0},
        '{ACT_ADD,    4'd0,  32'd0,        32'd0,        64'd0, 5'd1, PREDICT, ST_OK,    5'd0},
        '{ACT_ADD,    4'd0,  32'd0,        32'hFFFF_FFFF, '1,   5'd1, PREDICT, ST_OK,    5'd0},
        '{ACT_ADD,    4'd0,  32'd0,        32'd0,        64'd1, 5'd1, FIXED,   ST_MISS,  5'd2},
        '{ACT_GET,    4'd1,  32'd0,        32'd0,        64'd0, 5'd1, PREDICT, ST_OK,    5'd0},
        '{ACT_GET,    4'd15, 32'd0,        32'd0,        64'd0, 5'd1, FIXED,   ST_RANGE, 5'd2},
        '{ACT_GET,    4'd2,  32'd0,        32'd0,        64'd0, 5'd1, FIXED,   ST_RANGE, 5'd2},
        '{ACT_UPDATE, 4'd0,  32'hFFFF_FFFF, 32'd0, 64'hA5A5_A5A5_A5A5_A5A5, 5'd1, PREDICT,
          ST_OK, 5'd0},
        '{ACT_REMOVE, 4'd0,  32'd0,        32'd0,        64'd0, 5'd1, PREDICT, ST_OK,    5'd0},
        '{ACT_ADD,    4'd0,  32'd0,        32'h100, 64'h0123_4567_89AB_CDEF, 5'd15, PREDICT,
          ST_OK, 5'd0},
        '{ACT_ADD,    4'd0,  32'd0,        32'h5555_5555, 64'd9, 5'd1, FIXED,  ST_FULL,  5'd16},
        '{ACT_ADD,    4'd0,  32'd0,        32'd0,        64'd9, 5'd1, FIXED,   ST_MISS,  5'd16},
        '{ACT_GET,    4'd15, 32'd0,        32'd0,        64'd0, 5'd1, PREDICT, ST_OK,    5'd0},
        '{ACT_UPDATE, 4'd0,  32'h10E, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 5'd1, PREDICT,
          ST_OK, 5'd0},
        '{ACT_REMOVE, 4'd0,  32'd0,        32'd0,        64'd0, 5'd1, PREDICT, ST_OK,    5'd0},
        '{ACT_REMOVE, 4'd0,  32'hAAAA_AAAA, 32'd0,       64'd0, 5'd1, PREDICT, ST_OK,    5'd0},
        '{ACT_GET,    4'd14, 32'd0,        32'd0,        64'd0, 5'd1, FIXED,   ST_RANGE, 5'd14}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    krt_chan_if #(.data_t(req_t)) req_ch ();
    krt_chan_if #(.data_t(rsp_t)) rsp_ch ();

    keyed_record_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Model of the table contents
    logic [KEY_W-1:0] key_rows [ROWS];
    logic [PAY_W-1:0] pay_rows [ROWS];
    int               rows_held = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    rsp_t        pending_results [$];
    int unsigned error_count   = 0;
    int unsigned results_seen  = 0;
    bit          quiet         = 1'b0;
    bit          long_hold_due = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("[%0t] result %0d: %s got %0h, expected %0h",
                 $realtime, results_seen, field, got, want);
    endtask

    function automatic int find_row(input logic [KEY_W-1:0] key);
        for (int r = 0; r < rows_held; r++)
        begin
            if (key_rows[r] == key)
                return r;
        end
        return -1;
    endfunction

    // Apply one action to the model table and return the result it gives.
    function automatic rsp_t predict_table_action(input req_t item);
        rsp_t res;
        int   hit;
        res        = '0;
        res.status = ST_OK;
        case (item.action)
            ACT_GET:
            begin
                if (int'(item.row_index) >= rows_held)
                    res.status = ST_RANGE;
                else
                begin
                    res.read_key     = key_rows[item.row_index];
                    res.read_payload = pay_rows[item.row_index];
                end
            end
            ACT_ADD:
            begin
                if (find_row(item.record_key) >= 0)
                    res.status = ST_MISS;
                else if (rows_held >= ROWS)
                    res.status = ST_FULL;
                else
                begin
                    key_rows[rows_held] = item.record_key;
                    pay_rows[rows_held] = item.record_payload;
                    rows_held++;
                end
            end
            ACT_UPDATE:
            begin
                res.status = ST_MISS;
                for (int r = 0; r < rows_held; r++)
                begin
                    if (key_rows[r] == item.search_key)
                    begin
                        key_rows[r] = item.record_key;
                        pay_rows[r] = item.record_payload;
                        res.status  = ST_OK;
                    end
                end
            end
            default:
            begin
                hit = find_row(item.search_key);
                if (hit < 0)
                    res.status = ST_MISS;
                else
                begin
                    // close the gap left by the removed row
                    for (int r = hit; r + 1 < rows_held; r++)
                    begin
                        key_rows[r] = key_rows[r + 1];
                        pay_rows[r] = pay_rows[r + 1];
                    end
                    rows_held--;
                end
            end
        endcase
        res.row_count = ROW_W'(rows_held);
        return res;
    endfunction

    // Favor keys that are stored or recur, so searches hit and adds collide.
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45 && rows_held > 0)
            return key_rows[$urandom_range(0, rows_held - 1)];
        if (roll < 88)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    function automatic req_t make_random_item(input bit growing);
        req_t        item;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (growing)
            item.action = (roll < 50) ? ACT_ADD : (roll < 70) ? ACT_GET :
                          (roll < 85) ? ACT_UPDATE : ACT_REMOVE;
        else
            item.action = (roll < 15) ? ACT_ADD : (roll < 35) ? ACT_GET :
                          (roll < 55) ? ACT_UPDATE : ACT_REMOVE;
        if (rows_held > 0 && $urandom_range(0, 4) != 0)
            item.row_index = IDX_W'($urandom_range(0, rows_held - 1));
        else
            item.row_index = IDX_W'($urandom_range(0, 15));
        item.search_key     = pick_key();
        item.record_key     = pick_key();
        item.record_payload = {$urandom(), $urandom()};
        return item;
    endfunction

    // Offer one item and hold it until the transfer; valid stays high after.
    task automatic offer(input req_t item, input bit fixed_result, input rsp_t fixed_want);
        rsp_t predicted;
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = predict_table_action(item);
        pending_results = {pending_results, fixed_result ? fixed_want : predicted};
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    initial
    begin : drive_requests
        req_t item;
        rsp_t want;
        bit   growing;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        growing      = 1'b0;
        key_pool[0]  = '0;
        key_pool[1]  = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();
        wait (rst_n);
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            for (int k = 0; k < directed_rows[i].reps; k++)
            begin
                item.action         = directed_rows[i].act;
                item.row_index      = directed_rows[i].idx;
                item.search_key     = directed_rows[i].skey;
                item.record_key     = directed_rows[i].rkey + KEY_W'(k);
                item.record_payload = directed_rows[i].pay + PAY_W'(k);
                want                = '0;
                want.status         = directed_rows[i].want_status;
                want.row_count      = directed_rows[i].want_rows;
                maybe_gap();
                offer(item, directed_rows[i].fixed_result, want);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
                growing = ~growing;
            quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            if (n == 150)
                long_hold_due = 1'b1;
            if (n == 350)
            begin
                // drain completely before going on
                req_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            else
                maybe_gap();
            offer(make_random_item(growing), PREDICT, '0);
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * ROWS + 8) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : drive_ready
        int hold;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_due)
            begin
                // hold off long enough for the block to back up its input
                long_hold_due = 1'b0;
                rsp_ch.ready <= 1'b0;
                for (hold = 0; hold < LONG_HOLD; hold++)
                    @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected transfer, status", 64'(rsp_ch.data.status), '0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.data.status !== want.status)
                    report_mismatch("status", 64'(rsp_ch.data.status), 64'(want.status));
                if (rsp_ch.data.row_count !== want.row_count)
                    report_mismatch("row_count", 64'(rsp_ch.data.row_count),
                                    64'(want.row_count));
                if (rsp_ch.data.read_key !== want.read_key)
                    report_mismatch("read_key", 64'(rsp_ch.data.read_key),
                                    64'(want.read_key));
                if (rsp_ch.data.read_payload !== want.read_payload)
                    report_mismatch("read_payload", rsp_ch.data.read_payload,
                                    want.read_payload);
            end
        end
    end

endmodule
